[rtl/signed_rotation_angle_2d_core_macros.svh]
// assertion macros for the signed rotation angle core
`ifndef SIGNED_ROTATION_ANGLE_2D_CORE_MACROS_SVH
`define SIGNED_ROTATION_ANGLE_2D_CORE_MACROS_SVH

// checked only out of reset
`define SRA2D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SRA2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sra2d_pkg.sv]
package sra2d_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int GUARD_BITS      = 8;
	localparam int ZFRAC           = 24;
	localparam int TABLE_LEN       = 24;

	localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int SHW  = $clog2(TABLE_LEN);

	localparam int XW   = COORD_WIDTH + GUARD_BITS + 3;
	localparam int ZW   = ZFRAC + 10;
	localparam int DW   = ZW + 1;
	localparam int RSH  = ZFRAC - ANGLE_FRAC_BITS;
	localparam int RW   = ANGLE_FRAC_BITS + 11;
	localparam int OW   = 16;
	localparam int IN_W = ((4 * COORD_WIDTH + 7) / 8) * 8;

	localparam logic signed [ZW-1:0] Z180      = ZW'(longint'(180) <<< ZFRAC);
	localparam logic signed [DW-1:0] RND_HALF  = DW'(longint'(1) <<< (RSH - 1));
	localparam logic signed [RW-1:0] HALF_TURN = RW'(180 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [RW-1:0] FULL_TURN = RW'(360 * (1 << ANGLE_FRAC_BITS));

	// atan(2^-i), degrees at 2^ZFRAC
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} vec_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
	} pair_t;

endpackage

[rtl/sra2d_pre.sv]
module sra2d_pre (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   v_in,
	input  logic [4*sra2d_pkg::COORD_WIDTH-1:0]    raw,
	output logic                                   rdy_out,
	input  logic                                   rdy_in,
	output logic                                   v_q,
	output sra2d_pkg::pair_t                       d_q
);

	function automatic sra2d_pkg::vec_t prep(
		logic signed [sra2d_pkg::COORD_WIDTH-1:0] cx,
		logic signed [sra2d_pkg::COORD_WIDTH-1:0] cy
	);
		sra2d_pkg::vec_t v;
		logic signed [sra2d_pkg::XW-1:0] gx;
		logic signed [sra2d_pkg::XW-1:0] gy;
		gx = sra2d_pkg::XW'(cx) <<< sra2d_pkg::GUARD_BITS;
		gy = sra2d_pkg::XW'(cy) <<< sra2d_pkg::GUARD_BITS;
		v.zero = (cx == '0) && (cy == '0);
		if (gx[sra2d_pkg::XW-1]) begin
			// left half plane: negate and start at +/-180
			v.x = -gx;
			v.y = -gy;
			v.z = gy[sra2d_pkg::XW-1] ? -sra2d_pkg::Z180 : sra2d_pkg::Z180;
		end else begin
			v.x = gx;
			v.y = gy;
			v.z = '0;
		end
		return v;
	endfunction

	localparam int CW = sra2d_pkg::COORD_WIDTH;

	sra2d_pkg::pair_t d_nxt;

	always_comb begin
		d_nxt.a = prep(raw[CW-1:0], raw[2*CW-1:CW]);
		d_nxt.b = prep(raw[3*CW-1:2*CW], raw[4*CW-1:3*CW]);
	end

	assign rdy_out = !v_q || rdy_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_out) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_in) begin
			d_q <= d_nxt;
		end
	end

endmodule

[rtl/sra2d_cell.sv]
module sra2d_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sra2d_pkg::SHW-1:0]    sh,
	input  logic                         v_in,
	input  sra2d_pkg::pair_t             d_in,
	output logic                         rdy_out,
	input  logic                         rdy_in,
	output logic                         v_q,
	output sra2d_pkg::pair_t             d_q
);

	function automatic sra2d_pkg::vec_t step(
		sra2d_pkg::vec_t v,
		logic [sra2d_pkg::SHW-1:0] s,
		logic signed [sra2d_pkg::ZW-1:0] ang
	);
		sra2d_pkg::vec_t r;
		logic signed [sra2d_pkg::XW-1:0] xs;
		logic signed [sra2d_pkg::XW-1:0] ys;
		xs = v.x >>> s;
		ys = v.y >>> s;
		r = v;
		if (!v.y[sra2d_pkg::XW-1]) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + ang;
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - ang;
		end
		return r;
	endfunction

	logic signed [sra2d_pkg::ZW-1:0] ang;
	sra2d_pkg::pair_t                d_nxt;

	assign ang = sra2d_pkg::ATAN_TAB[sh];

	always_comb begin
		d_nxt.a = step(d_in.a, sh, ang);
		d_nxt.b = step(d_in.b, sh, ang);
	end

	assign rdy_out = !v_q || rdy_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_out) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_in) begin
			d_q <= d_nxt;
		end
	end

endmodule

[rtl/sra2d_post.sv]
module sra2d_post (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_in,
	input  sra2d_pkg::pair_t                d_in,
	output logic                            rdy_out,
	input  logic                            rdy_in,
	output logic                            v_s2,
	output logic signed [sra2d_pkg::OW-1:0] ang_s2
);

	function automatic logic signed [sra2d_pkg::RW-1:0] wrap1(
		logic signed [sra2d_pkg::RW-1:0] r
	);
		logic signed [sra2d_pkg::RW-1:0] w;
		if (r <= -sra2d_pkg::HALF_TURN) begin
			w = r + sra2d_pkg::FULL_TURN;
		end else if (r > sra2d_pkg::HALF_TURN) begin
			w = r - sra2d_pkg::FULL_TURN;
		end else begin
			w = r;
		end
		return w;
	endfunction

	logic                            v_s1;
	logic signed [sra2d_pkg::RW-1:0] r_s1;
	logic signed [sra2d_pkg::ZW-1:0] za;
	logic signed [sra2d_pkg::ZW-1:0] zb;
	logic signed [sra2d_pkg::DW-1:0] dsum;
	logic signed [sra2d_pkg::DW-1:0] dsh;
	logic signed [sra2d_pkg::RW-1:0] wr;
	logic                            rdy1;
	logic                            rdy2;

	assign za   = d_in.a.zero ? '0 : d_in.a.z;
	assign zb   = d_in.b.zero ? '0 : d_in.b.z;
	assign dsum = sra2d_pkg::DW'(za) - sra2d_pkg::DW'(zb) + sra2d_pkg::RND_HALF;
	assign dsh  = dsum >>> sra2d_pkg::RSH;
	assign wr   = wrap1(wrap1(r_s1));

	assign rdy2    = !v_s2 || rdy_in;
	assign rdy1    = !v_s1 || rdy2;
	assign rdy_out = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= v_in;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && v_in) begin
			r_s1 <= dsh[sra2d_pkg::RW-1:0];
		end
		if (rdy2 && v_s1) begin
			ang_s2 <= sra2d_pkg::OW'(wr);
		end
	end

endmodule

[rtl/signed_rotation_angle_2d_core.sv]
// Signed rotation from the first point to the second, in degrees x 128, wrapped into
// (-180, 180], clockwise positive; a zero vector has angle 0 and exact opposition gives
// +180. Both polar angles come from one row of 16 vectoring CORDIC cells, one iteration
// each, fed by an input prep stage and followed by a round and a wrap stage. One word is
// taken every clock while the output is not held back; a taken word passes through 19
// register stages (prep, 16 cells, 2 output stages) on its way to the output.
// Each stage holds its word only while the next one is full and stalled, so bubbles are
// squeezed out under back-pressure.
module signed_rotation_angle_2d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first_x, first_y, second_x, second_y
	input  logic [sra2d_pkg::IN_W-1:0]    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// angle_deg
	output logic [sra2d_pkg::OW-1:0]      m_tdata
);

	localparam int NSTG = sra2d_pkg::NSTG;

	sra2d_pkg::pair_t                chain_d [NSTG+1];
	logic                            chain_v [NSTG+1];
	logic                            chain_r [NSTG+1];
	logic signed [sra2d_pkg::OW-1:0] ang;

	sra2d_pre u_pre (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (s_tvalid),
		.raw     (s_tdata[4*sra2d_pkg::COORD_WIDTH-1:0]),
		.rdy_out (s_tready),
		.rdy_in  (chain_r[0]),
		.v_q     (chain_v[0]),
		.d_q     (chain_d[0])
	);

	for (genvar k = 0; k < NSTG; k++) begin : g_cell
		sra2d_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.sh      (sra2d_pkg::SHW'(k)),
			.v_in    (chain_v[k]),
			.d_in    (chain_d[k]),
			.rdy_out (chain_r[k]),
			.rdy_in  (chain_r[k+1]),
			.v_q     (chain_v[k+1]),
			.d_q     (chain_d[k+1])
		);
	end

	sra2d_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (chain_v[NSTG]),
		.d_in    (chain_d[NSTG]),
		.rdy_out (chain_r[NSTG]),
		.rdy_in  (m_tready),
		.v_s2    (m_tvalid),
		.ang_s2  (ang)
	);

	assign m_tdata = ang;

endmodule

[rtl/sra2d_checker.sv]
`include "signed_rotation_angle_2d_core_macros.svh"

module sra2d_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [sra2d_pkg::OW-1:0] m_tdata
);

	localparam int HALF = 180 * (1 << sra2d_pkg::ANGLE_FRAC_BITS);

	`SRA2D_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "word dropped while stalled")
	`SRA2D_ASSERT(a_data_hold, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "word changed while stalled")
	`SRA2D_ASSERT(a_ready_chain, clk, arst_n, m_tready |-> s_tready, "input stalled with output free")
	`SRA2D_ASSERT(a_range, clk, arst_n, m_tvalid |-> (($signed(m_tdata) > -HALF) && ($signed(m_tdata) <= HALF)), "angle out of range")
	`SRA2D_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_tvalid, "output valid in reset")

endmodule

bind signed_rotation_angle_2d_core sra2d_checker u_chk (.*);

[tb/sv/signed_rotation_angle_2d_core_tb.sv]
module signed_rotation_angle_2d_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  N_STAGES   = 16;
	localparam int  GUARD      = 8;
	localparam int  Z_FRAC     = 24;
	localparam int  OUT_FRAC   = 7;
	localparam longint HALF_TURN = 180 <<< OUT_FRAC;
	localparam int  N_RANDOM   = 400;
	localparam int  SETTLE     = 40;

	// atan(2^-k) in degrees << 24
	localparam longint ATAN_STEP [N_STAGES] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335
	};

	typedef struct packed {
		logic signed [15:0] second_y;
		logic signed [15:0] second_x;
		logic signed [15:0] first_y;
		logic signed [15:0] first_x;
	} point_pair_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sra2d_pkg::IN_W-1:0]     s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sra2d_pkg::OW-1:0]       m_tdata;

	point_pair_t          pair_q[$];
	logic signed [15:0]   angle_q[$];
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   fail_cnt = 0;

	signed_rotation_angle_2d_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// polar angle, degrees << 24
	function automatic longint vector_angle(longint px, longint py);
		longint ax, ay, az, sx, sy;
		ax = px <<< GUARD;
		ay = py <<< GUARD;
		az = 0;
		if (px == 0 && py == 0)
			return 0;
		if (ax < 0) begin
			az = (ay >= 0 ? 64'sd180 : -64'sd180) <<< Z_FRAC;
			ax = -ax;
			ay = -ay;
		end
		for (int k = 0; k < N_STAGES; k++) begin
			sx = ax >>> k;
			sy = ay >>> k;
			if (ay >= 0) begin
				ax = ax + sy;
				ay = ay - sx;
				az = az + ATAN_STEP[k];
			end else begin
				ax = ax - sy;
				ay = ay + sx;
				az = az - ATAN_STEP[k];
			end
		end
		return az;
	endfunction

	function automatic logic signed [15:0] rotation_angle(point_pair_t p);
		longint diff, r;
		diff = vector_angle(p.first_x, p.first_y) - vector_angle(p.second_x, p.second_y);
		r = (diff + (64'sd1 <<< (Z_FRAC - OUT_FRAC - 1))) >>> (Z_FRAC - OUT_FRAC);
		while (r <= -HALF_TURN)
			r = r + 2 * HALF_TURN;
		while (r > HALF_TURN)
			r = r - 2 * HALF_TURN;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] pick_coord(int mode);
		int sel;
		sel = $urandom_range(4);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(8)) - 4);
			default: begin
				case (sel)
					0: return -16'sd32768;
					1: return -16'sd1;
					2: return 16'sd0;
					3: return 16'sd1;
					default: return 16'sd32767;
				endcase
			end
		endcase
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		int mode, kind;
		kind = $urandom_range(9);
		mode = (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
		p.first_x  = pick_coord(mode);
		p.first_y  = pick_coord(mode);
		p.second_x = pick_coord(mode);
		p.second_y = pick_coord(mode);
		// opposite, equal or axis-mirrored points
		if (kind == 9) begin
			p.second_x = $urandom_range(1) ? -p.first_x : p.first_x;
			p.second_y = $urandom_range(1) ? -p.first_y : p.first_y;
		end
		return p;
	endfunction

	task automatic add_pair(int fx, int fy, int sx, int sy);
		point_pair_t p;
		p.first_x  = 16'(fx);
		p.first_y  = 16'(fy);
		p.second_x = 16'(sx);
		p.second_y = 16'(sy);
		pair_q.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				angle_q.push_back(rotation_angle(point_pair_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (pair_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pair_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (angle_q.size() == 0) begin
					$error("angle_deg: unexpected word %0d", $signed(m_tdata));
					fail_cnt++;
				end else begin
					want = angle_q.pop_front();
					if (want !== $signed(m_tdata)) begin
						$error("angle_deg: expected %0d, got %0d", want, $signed(m_tdata));
						fail_cnt++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#2ms;
		$display("signed_rotation_angle_2d_core_tb: FAIL");
		$finish;
	end

	initial begin
		static int idle_tab  [4] = '{0, 68, 0, 15};
		static int stall_tab [4] = '{0, 0, 68, 15};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero vectors, axes, extremes, left half plane, opposition
		add_pair(0, 0, 0, 0);
		add_pair(0, 0, 100, 100);
		add_pair(-100, -100, 0, 0);
		add_pair(32767, 0, 0, 32767);
		add_pair(0, 32767, 32767, 0);
		add_pair(-32768, 0, 32767, 0);
		add_pair(32767, 0, -32768, 0);
		add_pair(-1, 0, 1, 0);
		add_pair(1, 0, -1, 0);
		add_pair(0, -1, 0, 1);
		add_pair(0, 1, 0, -1);
		add_pair(-32768, -32768, 32767, 32767);
		add_pair(32767, 32767, -32768, -32768);
		add_pair(-32768, 32767, -32768, -32768);
		add_pair(-32768, -1, -32768, 0);
		add_pair(-5, 0, -5, -1);
		add_pair(-1, -1, 1, 1);
		add_pair(1, -1, -1, 1);
		add_pair(-32768, -32768, -32768, -32768);
		add_pair(32767, -32768, -32768, 32767);
		add_pair(3, 4, -4, 3);
		add_pair(-7, 2, -7, -2);
		add_pair(0, -32768, 0, 32767);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			for (int n = 0; n < N_RANDOM; n++)
				pair_q.push_back(random_pair());
			while (pair_q.size() > 0 || s_tvalid || angle_q.size() > 0)
				@(posedge clk);
		end

		repeat (SETTLE) @(posedge clk);
		if (fail_cnt == 0 && angle_q.size() == 0)
			$display("signed_rotation_angle_2d_core_tb: PASS");
		else
			$display("signed_rotation_angle_2d_core_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/sra2d_pkg.sv
rtl/sra2d_pre.sv
rtl/sra2d_cell.sv
rtl/sra2d_post.sv
rtl/signed_rotation_angle_2d_core.sv
rtl/sra2d_checker.sv
tb/sv/signed_rotation_angle_2d_core_tb.sv
